[hw/rtl/lbaf_pkg.sv]
// ----------------------------------------------------------------------------
// lbaf_pkg
// Shared types and constants of the line box average filter.
// ----------------------------------------------------------------------------
package lbaf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int RADIUS_BITS = 4;
   localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 4'd1;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          line_end;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic                          last_of_line;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic sum_load;
      logic sum_step;
      logic div_load;
      logic div_step;
      logic out_load;
      logic pos_next;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic any_out;
      logic read_last;
      logic div_last;
      logic slot_free;
      logic pos_last;
   } sts_type;

endpackage

[hw/rtl/lbaf_ram.sv]
// ----------------------------------------------------------------------------
// lbaf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbaf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/lbaf_ctrl.sv]
// ----------------------------------------------------------------------------
// lbaf_ctrl
// Sequencer: accepts a request, then for each output position walks the
// window sum, the divide and the output load.
// ----------------------------------------------------------------------------
module lbaf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output lbaf_pkg::cmd_type cmd,
   input  lbaf_pkg::sts_type sts
);
   import lbaf_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LOAD  = 7'b0000010,
      ST_SUM   = 7'b0000100,
      ST_ADD   = 7'b0001000,
      ST_DIVLD = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_PUT   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (sts.any_out) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            cmd.sum_load = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.read_last) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            // last read data lands in the accumulator here
            state_in = ST_DIVLD;
         end
         ST_DIVLD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (sts.slot_free) begin
               cmd.out_load = 1'b1;
               if (sts.pos_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pos_next = 1'b1;
                  state_in     = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

[hw/rtl/lbaf_dp.sv]
// ----------------------------------------------------------------------------
// lbaf_dp
// Datapath: window store, line position, window sum, radix-2 divider and
// output register.
// ----------------------------------------------------------------------------
module lbaf_dp #(
   parameter int MAX_RADIUS = 15,
   parameter int MAX_LINE   = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lbaf_pkg::cmd_type                    cmd,
   output lbaf_pkg::sts_type                    sts,
   input  lbaf_pkg::req_type                    req_payload,
   input  logic                                 csr_wr_en,
   input  logic [lbaf_pkg::RADIUS_BITS-1:0]     csr_wr_data,
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output lbaf_pkg::rsp_type                    rsp_payload
);
   import lbaf_pkg::*;

   localparam int DEPTH  = 2 * MAX_RADIUS + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = $clog2(MAX_LINE);
   localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
   localparam int CMP_W  = ((POS_W > RAD_W) ? POS_W : RAD_W) + 1;
   localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 2);
   localparam int SUM_W  = SAMPLE_BITS + CNT_W;
   localparam int ITER_W = $clog2(SAMPLE_BITS);

   // configuration and line tracking
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;
   logic [POS_W-1:0]       line_pos_ff, line_pos_in;
   logic [ADDR_W-1:0]      wr_ptr_ff, wr_ptr_in;

   // per-request context
   logic [POS_W-1:0]  q_ff, q_in;
   logic [RAD_W-1:0]  r_ff, r_in;
   logic              end_ff, end_in;
   logic [ADDR_W-1:0] newest_ff, newest_in;
   logic [POS_W-1:0]  p_ff, p_in;
   logic [POS_W-1:0]  pend_ff, pend_in;

   // window sum
   logic [ADDR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic                     acc_vld_ff, acc_vld_in;
   logic signed [SUM_W-1:0]  acc_ff, acc_in;

   // divider
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] dvd_ff, dvd_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       div_cnt_ff, div_cnt_in;
   logic [ITER_W-1:0]      iter_ff, iter_in;

   // output register
   logic    out_vld_ff, out_vld_in;
   rsp_type out_ff, out_in;

   logic [RAD_W-1:0]       r_live;
   logic [CMP_W-1:0]       q_live_x, r_live_x, q_x, r_x, p_x;
   logic                   q_ge_r;
   logic [CNT_W-1:0]       span;
   logic [SAMPLE_BITS-1:0] rd_data;
   logic [SUM_W-1:0]       mag;
   logic [CNT_W:0]         trial, diff;
   logic                   ge;
   logic [SAMPLE_BITS-1:0] quot;

   lbaf_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (cmd.accept),
      .wr_addr(wr_ptr_ff),
      .wr_data(req_payload.sample),
      .rd_en  (cmd.sum_step),
      .rd_addr(rd_ptr_ff),
      .rd_data(rd_data)
   );

   // radius above MAX_RADIUS saturates to MAX_RADIUS
   assign r_live   = (32'(radius_ff) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_ff);
   assign q_live_x = CMP_W'(line_pos_ff);
   assign r_live_x = CMP_W'(r_live);
   assign q_ge_r   = (q_live_x >= r_live_x);

   assign q_x  = CMP_W'(q_ff);
   assign r_x  = CMP_W'(r_ff);
   assign p_x  = CMP_W'(p_ff);
   // window runs from max(p - r, 0) up to q, span is its length minus one
   assign span = (p_x >= r_x) ? CNT_W'(q_x - p_x + r_x) : CNT_W'(q_x);

   assign mag   = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
   assign trial = {rem_ff, dvd_ff[SAMPLE_BITS-1]};
   assign ge    = (trial >= {1'b0, div_cnt_ff});
   assign diff  = trial - {1'b0, div_cnt_ff};
   assign quot  = neg_ff ? SAMPLE_BITS'(~dvd_ff + 1'b1) : dvd_ff;

   always_comb begin
      radius_in   = radius_ff;
      line_pos_in = line_pos_ff;
      wr_ptr_in   = wr_ptr_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      end_in      = end_ff;
      newest_in   = newest_ff;
      p_in        = p_ff;
      pend_in     = pend_ff;

      if (csr_wr_en) begin
         radius_in = csr_wr_data;
      end

      if (cmd.accept) begin
         q_in      = line_pos_ff;
         r_in      = r_live;
         end_in    = req_payload.line_end;
         newest_in = wr_ptr_ff;
         wr_ptr_in = (wr_ptr_ff == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         p_in      = q_ge_r ? POS_W'(q_live_x - r_live_x) : '0;
         pend_in   = req_payload.line_end ? line_pos_ff : POS_W'(q_live_x - r_live_x);
         if (req_payload.line_end) begin
            line_pos_in = '0;
         end else if (line_pos_ff < POS_W'(MAX_LINE - 1)) begin
            line_pos_in = line_pos_ff + 1'b1;
         end
      end else if (cmd.pos_next) begin
         p_in = p_ff + 1'b1;
      end
   end

   always_comb begin
      rd_ptr_in  = rd_ptr_ff;
      left_in    = left_ff;
      acc_vld_in = cmd.sum_step;
      acc_in     = acc_ff;
      if (cmd.sum_load) begin
         rd_ptr_in = newest_ff;
         left_in   = span;
         acc_in    = '0;
      end else begin
         if (cmd.sum_step) begin
            // walk back from the newest sample
            rd_ptr_in = (rd_ptr_ff == '0) ? ADDR_W'(DEPTH - 1) : rd_ptr_ff - 1'b1;
            left_in   = left_ff - 1'b1;
         end
         if (acc_vld_ff) begin
            acc_in = acc_ff + SUM_W'(signed'(rd_data));
         end
      end
   end

   always_comb begin
      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      neg_in     = neg_ff;
      div_cnt_in = div_cnt_ff;
      iter_in    = iter_ff;
      if (cmd.div_load) begin
         // magnitude is at most count << (sample bits - 1), so the top part is below count
         rem_in     = CNT_W'(mag[SUM_W-2:SAMPLE_BITS]);
         dvd_in     = mag[SAMPLE_BITS-1:0];
         neg_in     = acc_ff[SUM_W-1];
         div_cnt_in = span + 1'b1;
         iter_in    = ITER_W'(SAMPLE_BITS - 1);
      end else if (cmd.div_step) begin
         rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         dvd_in  = {dvd_ff[SAMPLE_BITS-2:0], ge};
         iter_in = iter_ff - 1'b1;
      end
   end

   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff;
      if (cmd.out_load) begin
         out_in.average      = signed'(quot);
         out_in.last_of_line = end_ff && (p_ff == q_ff);
         out_vld_in          = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= RADIUS_RESET;
         line_pos_ff <= '0;
         wr_ptr_ff   <= '0;
         acc_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         radius_ff   <= radius_in;
         line_pos_ff <= line_pos_in;
         wr_ptr_ff   <= wr_ptr_in;
         acc_vld_ff  <= acc_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff       <= q_in;
      r_ff       <= r_in;
      end_ff     <= end_in;
      newest_ff  <= newest_in;
      p_ff       <= p_in;
      pend_ff    <= pend_in;
      rd_ptr_ff  <= rd_ptr_in;
      left_ff    <= left_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      neg_ff     <= neg_in;
      div_cnt_ff <= div_cnt_in;
      iter_ff    <= iter_in;
      out_ff     <= out_in;
   end

   assign sts.any_out   = q_ge_r || req_payload.line_end;
   assign sts.read_last = (left_ff == '0);
   assign sts.div_last  = (iter_ff == '0);
   assign sts.slot_free = !out_vld_ff || !rsp_stall;
   assign sts.pos_last  = (p_ff == pend_ff);

   assign rsp_valid   = out_vld_ff;
   assign rsp_payload = out_ff;

endmodule

[hw/rtl/line_box_average_filter.sv]
// A request with no output is accepted and the sequencer stays idle. Each output
// clears the sum, reads terms = window length after clipping (up to 2 * radius + 1)
// at one store read a cycle, adds the last read, runs the radix-2 divider and loads
// the output. A line-end request gives up to radius + 1 outputs (fewer on a short
// line); the next request waits for all of them, and a full, stalled output holds off a load.
// Reset: radius 1, line position 0, no output pending; window store is not cleared.
// ----------------------------------------------------------------------------
// line_box_average_filter
// Edge-normalized box average along a line of signed samples, one request per
// sample, with the line tail flushed at the line's last sample.
// ----------------------------------------------------------------------------
module line_box_average_filter #(
   parameter int MAX_RADIUS = 15,
   parameter int MAX_LINE   = 4096
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  lbaf_pkg::req_type                req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output lbaf_pkg::rsp_type                rsp_payload,
   input  logic                             csr_wr_en,
   input  logic [lbaf_pkg::RADIUS_BITS-1:0] csr_wr_data
);
   import lbaf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   lbaf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   lbaf_dp #(
      .MAX_RADIUS(MAX_RADIUS),
      .MAX_LINE  (MAX_LINE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_payload(req_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

endmodule
